@@ rtl/core/ptq_pkg.sv @@
// Package for the periodic timer queue: entry type, operation and result codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ptq_pkg;

    localparam int unsigned CAPACITY_DEF = 16;
    localparam int unsigned MAX_FIRE     = 16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        K_ADDED    = 3'd0,
        K_FULL     = 3'd1,
        K_REMOVED  = 3'd2,
        K_NOTFOUND = 3'd3,
        K_FIRED    = 3'd4,
        K_IDLE     = 3'd5
    } kind_t;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] deadline;
        logic [15:0] period;
        logic [15:0] total;
        logic [15:0] done;
    } entry_t;

    // Commands broadcast from the controller to every cell.
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        entry_t      ins;      // entry to insert
        logic [31:0] key_id;   // delete: id to match; unused for pops
        logic        pop;      // delete head instead of matching id
    } bus_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_REMOVE,
        ST_POP,
        ST_REARM,
        ST_OUT
    } state_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Sort key: a before b when a's deadline is earlier, or equal with id not greater.
    function automatic logic key_le(input entry_t a, input entry_t b);
        return (a.deadline < b.deadline) ||
               ((a.deadline == b.deadline) && (a.id <= b.id));
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/periodic_timer_queue.sv @@
// Top level of the periodic timer queue: controller, fire buffer, output register.
// Depends on ptq_pkg, ptq_chain (and ptq_cell below it).
//
//  channel | dir | ports                                        | meaning
//  s_      | in  | s_valid s_ready s_operation ... s_target_id  | add / remove / tick
//  m_      | out | m_valid m_ready m_kind m_timer_id m_last_result | one result each
//
// Add: inserts into the sorted chain and loads the result register together.
// Remove: parallel id match and shift in the chain.
// Tick: pops each due head entry into the fire buffer until none is due or the
// buffer is full, then for each fired timer re-inserts or drops it and presents
// its result; an idle tick presents a single K_IDLE result.
// The chain of cells is the single shared structure, so one item is in work
// at a time. Reset is synchronous (aresetn low) and empties the queue.
// A stalled result port holds the controller in place; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
module periodic_timer_queue #(
    parameter int unsigned CAPACITY = ptq_pkg::CAPACITY_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [31:0] s_now_time,
    input  wire logic [15:0] s_repeat_total,
    input  wire logic [15:0] s_period,
    input  wire logic        s_fire_early,
    input  wire logic [15:0] s_first_delay,
    input  wire logic [31:0] s_target_id,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_kind,
    output logic [31:0]      m_timer_id,
    output logic             m_last_result
);
    import ptq_pkg::*;

    localparam int unsigned FW = $clog2(MAX_FIRE);

    state_t      state_reg, state_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] id_counter_reg, id_counter_next;
    logic [31:0] tgt_reg, tgt_next;
    entry_t      add_reg, add_next;
    // Fire buffer: popped entries, replayed in order.
    entry_t      fbuf_reg [MAX_FIRE];
    logic [FW:0] fcnt_reg, fcnt_next;
    logic [FW:0] fidx_reg, fidx_next;
    logic        fpush;

    logic        mv_reg, mv_next;
    logic [2:0]  mk_reg, mk_next;
    logic [31:0] mid_reg, mid_next;
    logic        ml_reg, ml_next;

    bus_t        bus;
    logic        full, found, head_valid;
    entry_t      head_entry;
    entry_t      cur, rearm;
    logic        drop;
    logic [15:0] done_inc;
    logic        out_free;

    ptq_chain #(.CAPACITY(CAPACITY)) u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .bus        (bus),
        .full       (full),
        .found      (found),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    assign out_free = !mv_reg || m_ready;
    assign cur      = fbuf_reg[fidx_reg[FW-1:0]];
    assign done_inc = (cur.done != 16'hFFFF) ? cur.done + 16'd1 : cur.done;
    assign drop     = (cur.total != 16'd0) && (done_inc >= cur.total);

    always_comb begin
        rearm          = cur;
        rearm.done     = (cur.total != 16'd0) ? done_inc : cur.done;
        rearm.deadline = sat_add(now_reg, cur.period);
    end

    always_comb begin
        state_next      = state_reg;
        now_next        = now_reg;
        id_counter_next = id_counter_reg;
        tgt_next        = tgt_reg;
        add_next        = add_reg;
        fcnt_next       = fcnt_reg;
        fidx_next       = fidx_reg;
        fpush           = 1'b0;
        bus             = '0;
        bus.cmd         = CMD_HOLD;
        s_ready         = 1'b0;
        mv_next         = mv_reg && !m_ready;
        mk_next         = mk_reg;
        mid_next        = mid_reg;
        ml_next         = ml_reg;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    now_next = s_now_time;
                    tgt_next = s_target_id;
                    add_next.id       = id_counter_reg;
                    add_next.deadline = sat_add(s_now_time,
                                                s_fire_early ? s_first_delay : s_period);
                    add_next.period   = s_period;
                    add_next.total    = s_repeat_total;
                    add_next.done     = 16'd0;
                    fcnt_next = '0;
                    fidx_next = '0;
                    case (op_t'(s_operation))
                        OP_ADD:    state_next = ST_ADD;
                        OP_REMOVE: state_next = ST_REMOVE;
                        OP_TICK:   state_next = ST_POP;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD: begin
                if (out_free) begin
                    mv_next  = 1'b1;
                    ml_next  = 1'b1;
                    if (full) begin
                        mk_next  = K_FULL;
                        mid_next = '0;
                    end else begin
                        bus.cmd         = CMD_INSERT;
                        bus.ins         = add_reg;
                        mk_next         = K_ADDED;
                        mid_next        = add_reg.id;
                        id_counter_next = id_counter_reg + 32'd1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_REMOVE: begin
                if (out_free) begin
                    bus.cmd    = CMD_DELETE;
                    bus.key_id = tgt_reg;
                    mv_next    = 1'b1;
                    ml_next    = 1'b1;
                    mk_next    = found ? K_REMOVED : K_NOTFOUND;
                    mid_next   = tgt_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_POP: begin
                if ((fcnt_reg != MAX_FIRE[FW:0]) && head_valid &&
                    (head_entry.deadline <= now_reg)) begin
                    bus.cmd   = CMD_DELETE;
                    bus.pop   = 1'b1;
                    fpush     = 1'b1;
                    fcnt_next = fcnt_reg + 1'b1;
                end else if (fcnt_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_REARM;
                end
            end
            ST_REARM: begin
                if (out_free) begin
                    if (!drop) begin
                        bus.cmd = CMD_INSERT;
                        bus.ins = rearm;
                    end
                    mv_next   = 1'b1;
                    mk_next   = K_FIRED;
                    mid_next  = cur.id;
                    ml_next   = (fidx_reg + 1'b1 == fcnt_reg);
                    fidx_next = fidx_reg + 1'b1;
                    if (fidx_reg + 1'b1 == fcnt_reg) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mk_next    = K_IDLE;
                    mid_next   = '0;
                    ml_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            id_counter_reg <= 32'd1;
            mv_reg         <= 1'b0;
            fcnt_reg       <= '0;
            fidx_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            id_counter_reg <= id_counter_next;
            mv_reg         <= mv_next;
            fcnt_reg       <= fcnt_next;
            fidx_reg       <= fidx_next;
        end
        now_reg <= now_next;
        tgt_reg <= tgt_next;
        add_reg <= add_next;
        mk_reg  <= mk_next;
        mid_reg <= mid_next;
        ml_reg  <= ml_next;
        if (fpush) begin
            fbuf_reg[fcnt_reg[FW-1:0]] <= head_entry;
        end
    end

    assign m_valid       = mv_reg;
    assign m_kind        = mk_reg;
    assign m_timer_id    = mid_reg;
    assign m_last_result = ml_reg;

    a_fire_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg <= MAX_FIRE[FW:0]) else $error("fire count overflow");
    a_replay: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_REARM |-> fidx_reg < fcnt_reg) else $error("replay past buffer");
    a_idle_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == K_IDLE |-> m_last_result) else $error("idle not last");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready) else $error("ready while busy");

endmodule
`default_nettype wire

@@ rtl/core/ptq_cell.sv @@
// One slot of the sorted timer chain; trades entries with both neighbors.
// Depends on ptq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptq_cell (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire ptq_pkg::bus_t   bus,
    input  wire logic            left_valid,   // neighbor toward the head
    input  wire ptq_pkg::entry_t left_entry,
    input  wire logic            left_place,   // neighbor took the insert or is past it
    input  wire logic            left_hit,     // delete point is at or before the left cell
    input  wire logic            right_valid,
    input  wire ptq_pkg::entry_t right_entry,
    input  wire logic            is_head,
    output logic                 valid,
    output ptq_pkg::entry_t      entry,
    output logic                 place,
    output logic                 hit
);
    import ptq_pkg::*;

    logic   valid_reg, valid_next;
    entry_t entry_reg, entry_next;
    logic   after_ins;
    logic   match;

    // Insert goes after every entry whose key is not greater than the new one.
    assign after_ins = !valid_reg || !key_le(entry_reg, bus.ins);
    assign place     = left_place || after_ins;
    assign match     = valid_reg && (bus.pop ? is_head : (entry_reg.id == bus.key_id));
    assign hit       = left_hit || match;

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        case (bus.cmd)
            CMD_INSERT: begin
                if (left_place) begin
                    valid_next = left_valid;
                    entry_next = left_entry;
                end else if (after_ins) begin
                    valid_next = 1'b1;
                    entry_next = bus.ins;
                end
            end
            CMD_DELETE: begin
                if (hit) begin
                    valid_next = right_valid;
                    entry_next = right_entry;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule
`default_nettype wire

@@ rtl/core/ptq_chain.sv @@
// Row of ptq_cell slots kept sorted; exposes head entry and search results.
// Depends on ptq_pkg and ptq_cell.
`timescale 1ns / 1ps
`default_nettype none
module ptq_chain #(
    parameter int unsigned CAPACITY = ptq_pkg::CAPACITY_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire ptq_pkg::bus_t   bus,
    output logic                 full,
    output logic                 found,
    output logic                 head_valid,
    output ptq_pkg::entry_t      head_entry
);
    import ptq_pkg::*;

    logic   v     [CAPACITY];
    entry_t e     [CAPACITY];
    logic   pl    [CAPACITY];
    logic   ht    [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic   lv, lp, lh, rv;
        entry_t le, re;
        if (i == 0) begin : g_first
            assign lv = 1'b0;
            assign le = '0;
            assign lp = 1'b0;
            assign lh = 1'b0;
        end else begin : g_mid
            assign lv = v[i-1];
            assign le = e[i-1];
            assign lp = pl[i-1];
            assign lh = ht[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign rv = 1'b0;
            assign re = '0;
        end else begin : g_inner
            assign rv = v[i+1];
            assign re = e[i+1];
        end
        ptq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .bus         (bus),
            .left_valid  (lv),
            .left_entry  (le),
            .left_place  (lp),
            .left_hit    (lh),
            .right_valid (rv),
            .right_entry (re),
            .is_head     (i == 0),
            .valid       (v[i]),
            .entry       (e[i]),
            .place       (pl[i]),
            .hit         (ht[i])
        );
    end

    assign full       = v[CAPACITY-1];
    assign found      = ht[CAPACITY-1];
    assign head_valid = v[0];
    assign head_entry = e[0];

    // Valid slots always form a prefix of the chain.
    for (genvar j = 1; j < CAPACITY; j++) begin : g_chk
        a_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
            v[j] |-> v[j-1]) else $error("ptq_chain: hole in chain");
    end

endmodule
`default_nettype wire

@@ bench/ptq_checker.sv @@
// Result checker for the periodic timer queue: mirrors the sorted timer list,
// predicts each result transaction and compares it. Depends on ptq_pkg.
`timescale 1ns / 1ps
module ptq_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [31:0] s_now_time,
    input  logic [15:0] s_repeat_total,
    input  logic [15:0] s_period,
    input  logic        s_fire_early,
    input  logic [15:0] s_first_delay,
    input  logic [31:0] s_target_id,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_kind,
    input  logic [31:0] m_timer_id,
    input  logic        m_last_result,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    import ptq_pkg::*;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] id;
        logic        last;
    } outcome_t;

    entry_t      timers[$];
    logic [31:0] next_id;
    outcome_t    expected_results[$];

    function automatic logic [31:0] deadline_after(logic [31:0] t, logic [15:0] d);
        logic [32:0] s;
        s = {1'b0, t} + {17'd0, d};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    task automatic place_timer(entry_t e);
        int pos;
        pos = 0;
        while (pos < timers.size() && (timers[pos].deadline < e.deadline ||
               (timers[pos].deadline == e.deadline && timers[pos].id <= e.id)))
            pos++;
        timers.insert(pos, e);
    endtask

    task automatic predict_outcomes(logic [1:0] op, logic [31:0] now, logic [15:0] tot,
                                    logic [15:0] per, logic early, logic [15:0] dly,
                                    logic [31:0] tgt);
        entry_t   e;
        entry_t   fired[$];
        outcome_t r;
        bit       hit;
        bit       drop;
        case (op)
            OP_ADD: begin
                if (timers.size() >= 16) begin
                    r = '{K_FULL, 32'd0, 1'b1};
                    expected_results.push_back(r);
                end else begin
                    e = '{next_id, deadline_after(now, early ? dly : per), per, tot, 16'd0};
                    r = '{K_ADDED, next_id, 1'b1};
                    next_id = next_id + 1;
                    place_timer(e);
                    expected_results.push_back(r);
                end
            end
            OP_REMOVE: begin
                hit = 0;
                foreach (timers[i]) begin
                    if (!hit && timers[i].id == tgt) begin
                        timers.delete(i);
                        hit = 1;
                    end
                end
                r = '{hit ? K_REMOVED : K_NOTFOUND, tgt, 1'b1};
                expected_results.push_back(r);
            end
            OP_TICK: begin
                while (fired.size() < 16 && timers.size() > 0 && timers[0].deadline <= now)
                    fired.push_back(timers.pop_front());
                if (fired.size() == 0) begin
                    r = '{K_IDLE, 32'd0, 1'b1};
                    expected_results.push_back(r);
                end
                foreach (fired[k]) begin
                    e = fired[k];
                    r = '{K_FIRED, e.id, k == fired.size() - 1};
                    expected_results.push_back(r);
                    drop = 0;
                    if (e.total != 0) begin
                        if (e.done != 16'hFFFF) e.done = e.done + 1;
                        drop = e.done >= e.total;
                    end
                    if (!drop) begin
                        e.deadline = deadline_after(now, e.period);
                        place_timer(e);
                    end
                end
            end
            default: ;  // unknown op: no result
        endcase
    endtask

    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            timers.delete();
            expected_results.delete();
            next_id = 32'd1;
            fail_count <= 0;
            result_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result kind=%0d id=%0h", m_kind, m_timer_id);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (m_kind !== want.kind || m_timer_id !== want.id ||
                        m_last_result !== want.last) begin
                        if (fail_count < 10)
                            $display("ERROR: exp kind=%0d id=%0h last=%0b got %0d %0h %0b",
                                     want.kind, want.id, want.last,
                                     m_kind, m_timer_id, m_last_result);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // predict on every accepted input transaction
            if (s_valid && s_ready)
                predict_outcomes(s_operation, s_now_time, s_repeat_total, s_period,
                                 s_fire_early, s_first_delay, s_target_id);
        end
    end

    assign pending_count = expected_results.size();
endmodule

@@ bench/tb_top.sv @@
// Testbench top for periodic_timer_queue: clock, reset, transaction stimulus,
// idling and the verdict. Depends on ptq_pkg, ptq_checker and the RTL.
`timescale 1ns / 1ps
module tb_top;
    import ptq_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_operation = OP_TICK;
    logic [31:0] s_now_time = 0;
    logic [15:0] s_repeat_total = 0;
    logic [15:0] s_period = 0;
    logic        s_fire_early = 0;
    logic [15:0] s_first_delay = 0;
    logic [31:0] s_target_id = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [2:0]  m_kind;
    logic [31:0] m_timer_id;
    logic        m_last_result;
    int          fail_count, pending_count, result_count;

    // Random idling on both sides; one stretch in the middle runs without it.
    bit          no_idle = 0;
    // Receiver hold-off for back-pressure, counted in its own process.
    bit          hold_off = 0;
    longint      cycle_count = 0;

    // Simulated clock of the timer domain: advances at random between items.
    logic [31:0] clock_now = 0;
    int          issued = 0;

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    periodic_timer_queue u_dut (.*);

    ptq_checker u_chk (.*);

    // Receiver: ready drops about 18% of cycles unless idling is off.
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 0;
        else m_ready <= !hold_off && (no_idle || $urandom_range(99) >= 18);
    end

    // Watchdog: far above the slowest correct run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // One transaction: valid held with payload steady until accepted.
    // Valid stays up after acceptance unless the next call idles first.
    task automatic send(logic [1:0] op, logic [31:0] now, logic [15:0] tot,
                        logic [15:0] per, logic early, logic [15:0] dly, logic [31:0] tgt);
        if (!no_idle && $urandom_range(99) < 18) begin
            s_valid <= 0;
            @(posedge aclk);
            while (!no_idle && $urandom_range(99) < 18) @(posedge aclk);
        end
        s_valid <= 1;
        s_operation <= op;
        s_now_time <= now;
        s_repeat_total <= tot;
        s_period <= per;
        s_fire_early <= early;
        s_first_delay <= dly;
        s_target_id <= tgt;
        do @(posedge aclk); while (!s_ready);
        issued++;
    endtask

    // Random add with small periods so timers actually come due.
    task automatic random_add();
        logic [15:0] tot;
        tot = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
        send(OP_ADD, clock_now, tot, 16'($urandom_range(12)), 1'($urandom),
             ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(8)),
             32'($urandom));
    endtask

    task automatic wait_drained();
        s_valid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    initial begin
        int pick;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: every operation, idle tick, unknown op, missing id,
        // saturating deadline, zero period, full queue and duplicate-free removal.
        send(OP_TICK, 32'd0, 0, 0, 0, 0, 0);
        send(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 32'hFFFF_FFFF);
        send(OP_REMOVE, 32'd5, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send(OP_ADD, 32'hFFFF_FFF0, 16'hFFFF, 16'hFFFF, 0, 0, 0);
        send(OP_ADD, 32'd10, 16'd2, 16'd0, 1, 16'd0, 0);
        send(OP_ADD, 32'd10, 16'd0, 16'd3, 1, 16'hFFFF, 0);
        send(OP_TICK, 32'd10, 0, 0, 0, 0, 0);
        send(OP_TICK, 32'd10, 0, 0, 0, 0, 0);
        send(OP_REMOVE, 32'd1, 0, 0, 0, 0, 32'd1);
        for (int i = 0; i < 17; i++)
            send(OP_ADD, 32'd20, 16'd1, 16'd0, 0, 0, 0);
        // Many due: all sixteen queued timers fire; the rearmed ones stay due.
        send(OP_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        send(OP_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        wait_drained();

        // Back-pressure: receiver holds off while the sender keeps offering.
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 8; i++) random_add();
        join

        // Random traffic; clock_now moves forward so timers fire in waves.
        clock_now = 32'd100;
        for (int n = 0; n < 300; n++) begin
            no_idle = (n >= 120 && n < 170);
            pick = $urandom_range(99);
            if ($urandom_range(3) == 0) clock_now = clock_now + $urandom_range(6);
            if (pick < 40) random_add();
            else if (pick < 58)
                send(OP_REMOVE, clock_now, 16'($urandom), 16'($urandom), 1'($urandom),
                     16'($urandom), ($urandom_range(4) == 0) ? 32'($urandom)
                                                             : 32'($urandom_range(40)));
            else if (pick < 95)
                send(OP_TICK, clock_now, 16'($urandom), 16'($urandom), 1'($urandom),
                     16'($urandom), 32'($urandom));
            else
                send(OP_NONE, 32'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                     16'($urandom), 32'($urandom));
        end
        no_idle = 0;

        wait_drained();
        $display("Sent %0d transactions, checked %0d results", issued, result_count);
        $display("Covered add, remove, tick, full queue, saturation and back-pressure");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

@@ periodic_timer_queue.f @@
rtl/core/ptq_pkg.sv
rtl/core/ptq_cell.sv
rtl/core/ptq_chain.sv
rtl/core/periodic_timer_queue.sv
bench/ptq_checker.sv
bench/tb_top.sv
